>>> sv/tph_pkg.sv
// Shared constants, request and register codes, and store control type
// for the two-axis profile histogram. No dependencies.
package tph_pkg;

  localparam int MAX_WIRES  = 64;
  localparam int COUNT_BITS = 32;
  localparam int ADDR_BITS  = $clog2(MAX_WIRES);
  localparam int WIRE_BITS  = $clog2(MAX_WIRES + 1);

  localparam logic [1:0] REQ_SAMPLE = 2'd0;
  localparam logic [1:0] REQ_READ   = 2'd1;
  localparam logic [1:0] REQ_CLEAR  = 2'd2;

  localparam logic [2:0] CFG_X_LIMIT    = 3'd0;
  localparam logic [2:0] CFG_Y_LIMIT    = 3'd1;
  localparam logic [2:0] CFG_BPM_HOR    = 3'd2;
  localparam logic [2:0] CFG_BPM_VER    = 3'd3;
  localparam logic [2:0] CFG_WIRE_COUNT = 3'd4;

  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  typedef struct packed {
    logic inc;
    logic clr;
  } store_ctl_t;

endpackage

>>> sv/tph_axis.sv
// One axis of the wire mapping: window test and scale multiply, registered,
// then offset, floor and clamp to a wire index. Uses tph_pkg.
module tph_axis (
  input  logic                           clk,
  input  logic                           en,
  input  logic signed [31:0]             pos,
  input  logic [30:0]                    half,
  input  logic [31:0]                    scale,
  input  logic [tph_pkg::WIRE_BITS-1:0]  wires,
  output logic                           hit,
  output logic [tph_pkg::ADDR_BITS-1:0]  idx
);
  import tph_pkg::*;

  logic        inwin;
  logic        neg;
  logic [63:0] prod;

  logic signed [32:0] pos_ext;
  logic signed [32:0] half_ext;
  logic [31:0]        mag;
  logic [63:0]        offs;
  logic [64:0]        sum;
  logic [31:0]        quot;
  logic [WIRE_BITS-1:0] wmax;

  assign pos_ext  = {pos[31], pos};
  assign half_ext = {2'b00, half};
  assign mag      = pos[31] ? 32'(-pos) : 32'(pos);

  always_ff @(posedge clk) begin
    if (en) begin
      inwin <= (pos_ext < half_ext) && (pos_ext > -half_ext);
      neg   <= pos[31];
      prod  <= 64'(mag) * 64'(scale);
    end
  end

  // wires/2 in Q32.32
  assign offs = 64'(wires) << 31;
  assign sum  = neg ? ({1'b0, offs} - {1'b0, prod}) : ({1'b0, prod} + {1'b0, offs});
  assign quot = (neg && sum[64]) ? 32'd0 : sum[63:32];
  assign wmax = wires - 1'b1;

  assign hit = inwin;
  assign idx = (quot > 32'(wmax)) ? ADDR_BITS'(wmax) : ADDR_BITS'(quot);

endmodule

>>> sv/tph_store.sv
// Wire counter store: memory with per-entry valid bits, registered read,
// saturating increment with write forwarding, all-entry clear. Uses tph_pkg.
module tph_store (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           en,
  input  logic [tph_pkg::ADDR_BITS-1:0]  rd_addr,
  input  tph_pkg::store_ctl_t            ctl,
  output logic [tph_pkg::COUNT_BITS-1:0] cur
);
  import tph_pkg::*;

  logic [COUNT_BITS-1:0] mem [MAX_WIRES];
  logic [MAX_WIRES-1:0]  vld;
  logic [ADDR_BITS-1:0]  addr;
  logic [COUNT_BITS-1:0] rd_data;
  logic                  rd_ok;
  logic                  fwd;
  logic [COUNT_BITS-1:0] fwd_data;
  logic [COUNT_BITS-1:0] upd;

  assign cur = fwd ? fwd_data : (rd_ok ? rd_data : '0);
  assign upd = (cur == CNT_MAX) ? cur : cur + 1'b1;

  always_ff @(posedge clk) begin
    if (en) begin
      rd_data  <= mem[rd_addr];
      addr     <= rd_addr;
      fwd_data <= upd;
      if (ctl.inc) begin
        mem[addr] <= upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld   <= '0;
      rd_ok <= 1'b0;
      fwd   <= 1'b0;
    end else if (en) begin
      rd_ok <= vld[rd_addr] && !ctl.clr;
      fwd   <= ctl.inc && (addr == rd_addr);
      if (ctl.clr) begin
        vld <= '0;
      end else if (ctl.inc) begin
        vld[addr] <= 1'b1;
      end
    end
  end

endmodule

>>> sv/two_axis_profile_histogram.sv
// Top level of the two-axis beam profile histogram.
// Depends on tph_pkg, tph_axis and tph_store.
//
// Requests enter on req_valid/req_stall: req_type selects sample, read or
// clear. A sample bins x_position and y_position on their own axes and
// bumps the matching wire counters; a read returns both counters at
// read_index; a clear zeroes both stores at once.
// Every request yields one result on rsp_valid/rsp_stall, in order.
// From acceptance to rsp_valid a request passes the input register, the
// multiply register, the store read register and the result register,
// in that order. One request per cycle is accepted back to back while no
// result waits under rsp_stall; counter hazards between neighbors are
// resolved by forwarding in the store.
// While a result waits under rsp_stall the whole pipeline holds and
// req_stall is high.
// Configuration is written through cfg_we/cfg_index/cfg_data while idle.
// Synchronous reset loads register defaults, empties the pipeline and marks
// every counter as zero through per-wire valid bits; no clearing pass.
module two_axis_profile_histogram (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               req_valid,
  output logic               req_stall,
  input  logic [1:0]         req_type,
  input  logic signed [31:0] x_position,
  input  logic signed [31:0] y_position,
  input  logic [5:0]         read_index,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output logic               hor_hit,
  output logic               ver_hit,
  output logic [5:0]         hor_bin,
  output logic [5:0]         ver_bin,
  output logic [31:0]        hor_count,
  output logic [31:0]        ver_count
);
  import tph_pkg::*;

  logic [30:0] x_limit;
  logic [30:0] y_limit;
  logic [31:0] bpm_hor;
  logic [31:0] bpm_ver;
  logic [6:0]  wire_count;
  logic [WIRE_BITS-1:0] eff_w;

  logic adv;

  // input stage
  logic               a_valid;
  logic [1:0]         a_type;
  logic signed [31:0] a_x;
  logic signed [31:0] a_y;
  logic [5:0]         a_ridx;

  // multiply stage
  logic       b_valid;
  logic [1:0] b_type;
  logic [5:0] b_ridx;

  // store stage
  logic                 c_valid;
  logic [1:0]           c_type;
  logic                 c_ridx_ok;
  logic                 c_hor_hit;
  logic                 c_ver_hit;
  logic [ADDR_BITS-1:0] c_hor_addr;
  logic [ADDR_BITS-1:0] c_ver_addr;

  logic                  b_hor_hit;
  logic                  b_ver_hit;
  logic [ADDR_BITS-1:0]  b_hor_idx;
  logic [ADDR_BITS-1:0]  b_ver_idx;
  logic [ADDR_BITS-1:0]  hor_rd_addr;
  logic [ADDR_BITS-1:0]  ver_rd_addr;
  logic                  b_sample;
  store_ctl_t            hor_ctl;
  store_ctl_t            ver_ctl;
  logic [COUNT_BITS-1:0] hor_cur;
  logic [COUNT_BITS-1:0] ver_cur;

  logic hh;
  logic vh;
  logic c_rd;

  assign adv       = !(rsp_valid && rsp_stall);
  assign req_stall = !adv;

  always_comb begin
    if (wire_count == 7'd0) begin
      eff_w = WIRE_BITS'(1);
    end else if (32'(wire_count) > 32'(MAX_WIRES)) begin
      eff_w = WIRE_BITS'(MAX_WIRES);
    end else begin
      eff_w = WIRE_BITS'(wire_count);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      x_limit    <= 31'd65536;
      y_limit    <= 31'd65536;
      bpm_hor    <= 32'd2097152;
      bpm_ver    <= 32'd2097152;
      wire_count <= 7'd64;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_X_LIMIT:    x_limit    <= cfg_data[30:0];
        CFG_Y_LIMIT:    y_limit    <= cfg_data[30:0];
        CFG_BPM_HOR:    bpm_hor    <= cfg_data;
        CFG_BPM_VER:    bpm_ver    <= cfg_data;
        CFG_WIRE_COUNT: wire_count <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      b_valid   <= 1'b0;
      c_valid   <= 1'b0;
      rsp_valid <= 1'b0;
    end else if (adv) begin
      a_valid   <= req_valid;
      b_valid   <= a_valid;
      c_valid   <= b_valid;
      rsp_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_type     <= req_type;
      a_x        <= x_position;
      a_y        <= y_position;
      a_ridx     <= read_index;
      b_type     <= a_type;
      b_ridx     <= a_ridx;
      c_type     <= b_type;
      c_ridx_ok  <= 32'(b_ridx) < 32'(MAX_WIRES);
      c_hor_hit  <= b_hor_hit;
      c_ver_hit  <= b_ver_hit;
      c_hor_addr <= hor_rd_addr;
      c_ver_addr <= ver_rd_addr;
    end
  end

  tph_axis u_hor (
    .clk   (clk),
    .en    (adv),
    .pos   (a_x),
    .half  (x_limit),
    .scale (bpm_hor),
    .wires (eff_w),
    .hit   (b_hor_hit),
    .idx   (b_hor_idx)
  );

  tph_axis u_ver (
    .clk   (clk),
    .en    (adv),
    .pos   (a_y),
    .half  (y_limit),
    .scale (bpm_ver),
    .wires (eff_w),
    .hit   (b_ver_hit),
    .idx   (b_ver_idx)
  );

  assign b_sample    = (b_type == REQ_SAMPLE);
  assign hor_rd_addr = b_sample ? b_hor_idx : ADDR_BITS'(b_ridx);
  assign ver_rd_addr = b_sample ? b_ver_idx : ADDR_BITS'(b_ridx);

  assign hh   = c_valid && (c_type == REQ_SAMPLE) && c_hor_hit;
  assign vh   = c_valid && (c_type == REQ_SAMPLE) && c_ver_hit;
  assign c_rd = (c_type == REQ_READ) && c_ridx_ok;

  assign hor_ctl.inc = hh;
  assign hor_ctl.clr = c_valid && (c_type == REQ_CLEAR);
  assign ver_ctl.inc = vh;
  assign ver_ctl.clr = c_valid && (c_type == REQ_CLEAR);

  tph_store u_hor_store (
    .clk     (clk),
    .rst     (rst),
    .en      (adv),
    .rd_addr (hor_rd_addr),
    .ctl     (hor_ctl),
    .cur     (hor_cur)
  );

  tph_store u_ver_store (
    .clk     (clk),
    .rst     (rst),
    .en      (adv),
    .rd_addr (ver_rd_addr),
    .ctl     (ver_ctl),
    .cur     (ver_cur)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      hor_hit   <= hh;
      ver_hit   <= vh;
      hor_bin   <= hh ? 6'(c_hor_addr) : 6'd0;
      ver_bin   <= vh ? 6'(c_ver_addr) : 6'd0;
      hor_count <= c_rd ? 32'(hor_cur) : 32'd0;
      ver_count <= c_rd ? 32'(ver_cur) : 32'd0;
    end
  end

  a_hor_bin_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !hor_hit |-> hor_bin == 6'd0)
    else $error("hor_bin set without a horizontal hit");

  a_ver_bin_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !ver_hit |-> ver_bin == 6'd0)
    else $error("ver_bin set without a vertical hit");

  a_hit_no_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (hor_hit || ver_hit) |-> hor_count == 32'd0 && ver_count == 32'd0)
    else $error("sample result carries counter values");

endmodule
